// ----- rtl/core/rcsb_pkg.sv -----
package rcsb_pkg;

    // Default parameter values
    localparam int DEF_MAX_KNOTS   = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_FIRST_KNOT = 2'd0;
    localparam logic [1:0] REG_LAST_KNOT  = 2'd1;
    localparam logic [1:0] REG_NUM_KNOTS  = 2'd2;

    // Reset values of the registers
    localparam logic [15:0] RST_FIRST_KNOT = 16'd3277;
    localparam logic [15:0] RST_LAST_KNOT  = 16'd62259;
    localparam logic [4:0]  RST_NUM_KNOTS  = 5'd5;

    // Fewest knots the spline is built with
    localparam logic [4:0] MIN_KNOTS = 5'd3;

    // 1.0 in Q16.16
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // Saturation limits
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // Quotient bits produced by the divider (doubled value, for rounding)
    localparam int QBITS = 34;

    typedef enum logic [1:0] {
        KIND_CONST,
        KIND_LIN,
        KIND_SPLINE
    } kind_t;

    // Per-column side information that travels with the arithmetic
    typedef struct packed {
        logic [3:0]  col;
        logic        last;
        kind_t       kind;
        logic        zero;
        logic        neg;
        logic [31:0] linval;
    } meta_t;

endpackage

// ----- rtl/core/rcsb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow check
module rcsb_div
    import rcsb_pkg::*;
#(
    parameter int CW   = 94,
    parameter int DENW = 60
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [CW-1:0]     in_rem,
    input  logic [DENW-1:0]   in_den,
    input  meta_t             in_meta,
    output logic              out_valid,
    output logic [QBITS-1:0]  out_quo,
    output logic              out_ovf,
    output meta_t             out_meta
);

    localparam int NST = QBITS + 1;

    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   ovf_reg;
    logic [CW-1:0]    rem_reg  [NST];
    logic [DENW-1:0]  den_reg  [NST];
    logic [QBITS-1:0] quo_reg  [NST];
    meta_t            meta_reg [NST];

    logic [CW-1:0] top_trial;

    assign top_trial = CW'(in_den) << QBITS;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Entry stage: operands registered, and a quotient too large for the result range flagged
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= in_rem;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= (in_rem >= top_trial);
            meta_reg[0] <= in_meta;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar i = 1; i < NST; i++)
    begin : g_stage
        localparam int B = QBITS - i;

        logic [CW-1:0]    trial;
        logic             ge;
        logic [CW-1:0]    rem_next;
        logic [QBITS-1:0] quo_next;

        always_comb
        begin
            trial    = CW'(den_reg[i-1]) << B;
            ge       = (rem_reg[i-1] >= trial);
            rem_next = ge ? (rem_reg[i-1] - trial) : rem_reg[i-1];
            quo_next = quo_reg[i-1] | (QBITS'(ge) << B);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_reg[i-1];
                quo_reg[i]  <= quo_next;
                ovf_reg[i]  <= ovf_reg[i-1];
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_quo   = quo_reg[NST-1];
    assign out_ovf   = ovf_reg[NST-1];
    assign out_meta  = meta_reg[NST-1];

endmodule

// ----- rtl/core/restricted_cubic_spline_basis.sv -----
// Restricted cubic spline basis generator. Each accepted sample_x produces a run of
// num_knots output words (clamped to 3..MAX_KNOTS), columns 0 upwards, with last_column
// set on the final one: column 0 is 1.0, column 1 is x scaled to Q16.16, and the others
// are the spline terms over equally spaced knots from first_knot_pos to last_knot_pos,
// rounded to nearest (ties away from zero) and saturated. A sequencer issues one column
// per clock, unless the pipeline stalls, into a fully pipelined datapath, so the next
// sample is taken as the last column of the current one issues; the output channel runs
// at one word per clock while out_ready is high. From issue to output a column passes
// 9 arithmetic stages, 35 divider stages and the output register, with rounding and
// saturation ahead of the output register.
// Back-pressure on the output stalls the whole pipeline without loss. Configuration must
// only be written while no sample is in flight.
module restricted_cubic_spline_basis
    import rcsb_pkg::*;
#(
    parameter int MAX_KNOTS   = DEF_MAX_KNOTS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic [SAMPLE_BITS-1:0]  sample_x,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [3:0]              column,
    output logic signed [31:0]      basis_value,
    output logic                    last_column
);

    localparam int S    = SAMPLE_BITS;
    localparam int XW   = S + 1;
    localparam int MW   = $clog2(MAX_KNOTS);
    localparam int KW   = $clog2(MAX_KNOTS + 1);
    localparam int PW   = XW + MW + 1;
    localparam int DW   = PW + 1;
    localparam int UW   = DW - 1;
    localparam int CUW  = 3 * UW;
    localparam int TW   = CUW + MW;
    localparam int NW   = TW + 2;
    localparam int AW   = NW - 1 + 17;
    localparam int D0W  = 3 * MW + 2 * S;
    localparam int DENW = D0W + S;
    localparam int CW   = (AW > DENW + QBITS) ? AW : DENW + QBITS;
    localparam int LW   = S + 17;

    localparam logic [LW-1:0] LIN_HALF = LW'(1) << (S - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    logic [15:0] first_knot_reg;
    logic [15:0] last_knot_reg;
    logic [4:0]  num_knots_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_knot_reg <= RST_FIRST_KNOT;
            last_knot_reg  <= RST_LAST_KNOT;
            num_knots_reg  <= RST_NUM_KNOTS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_KNOT: first_knot_reg <= cfg_data;
                REG_LAST_KNOT:  last_knot_reg  <= cfg_data;
                REG_NUM_KNOTS:  num_knots_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [S-1:0] f_s;
    logic [S-1:0] l_s;

    assign f_s = S'(first_knot_reg);
    assign l_s = S'(last_knot_reg);

    // Pipeline advances whenever the output register can take a word
    logic adv;
    logic out_valid_reg;

    assign adv = !out_valid_reg || out_ready;

    // ---------------------------------------------------------------
    // Column sequencer
    logic            active_reg;
    logic [S-1:0]    x_reg;
    logic [KW-1:0]   col_reg;
    logic [KW-1:0]   k_eff;
    logic            last_issue;
    logic            src_fire;
    logic            in_fire;

    always_comb
    begin
        if (num_knots_reg < MIN_KNOTS)
            k_eff = KW'(MIN_KNOTS);
        else if (int'(num_knots_reg) > MAX_KNOTS)
            k_eff = KW'(MAX_KNOTS);
        else
            k_eff = KW'(num_knots_reg);
    end

    assign last_issue   = (col_reg == k_eff - KW'(1));
    assign src_fire     = active_reg && adv;
    assign sample_ready = !active_reg || (adv && last_issue);
    assign in_fire      = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            col_reg    <= '0;
        end
        else if (in_fire)
        begin
            active_reg <= 1'b1;
            col_reg    <= '0;
        end
        else if (src_fire)
        begin
            if (last_issue)
                active_reg <= 1'b0;
            else
                col_reg <= col_reg + KW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= sample_x;
    end

    // Side information for the issued column
    meta_t        meta_issue;
    logic [LW-1:0] lin_sum;

    always_comb
    begin
        lin_sum           = {1'b0, x_reg, 16'h0} + LIN_HALF;
        meta_issue.col    = 4'(col_reg);
        meta_issue.last   = last_issue;
        meta_issue.zero   = (f_s == l_s);
        meta_issue.neg    = 1'b0;
        meta_issue.linval = 32'(lin_sum >> S);
        if (col_reg == KW'(0))
            meta_issue.kind = KIND_CONST;
        else if (col_reg == KW'(1))
            meta_issue.kind = KIND_LIN;
        else
            meta_issue.kind = KIND_SPLINE;
    end

    // ---------------------------------------------------------------
    // Stage A: issued column
    logic          va_reg;
    logic [S-1:0]  xa_reg;
    logic [KW-1:0] ja_reg;
    logic [KW-1:0] ka_reg;
    meta_t         ma_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xa_reg <= x_reg;
            ja_reg <= col_reg;
            ka_reg <= k_eff;
            ma_reg <= meta_issue;
        end
    end

    // Stage B: scaled offset, knot steps, span square, m square
    logic signed [XW-1:0] dx_b;
    logic signed [XW-1:0] sp_b;
    logic [S-1:0]         sabs_b;
    logic [MW-1:0]        m_b;
    logic [MW-1:0]        ia_idx;
    logic [MW-1:0]        ic_idx;
    logic signed [XW-1:0] sp_neg;

    always_comb
    begin
        dx_b   = $signed({1'b0, xa_reg}) - $signed({1'b0, f_s});
        sp_b   = $signed({1'b0, l_s}) - $signed({1'b0, f_s});
        sp_neg = -sp_b;
        sabs_b = sp_b[XW-1] ? sp_neg[S-1:0] : sp_b[S-1:0];
        m_b    = MW'(ka_reg - KW'(1));
        ia_idx = MW'(ja_reg - KW'(2));
        ic_idx = MW'(ka_reg - KW'(2));
    end

    logic                 vb_reg;
    logic signed [PW-1:0] pb_reg;
    logic signed [PW-1:0] iab_reg;
    logic signed [PW-1:0] ibb_reg;
    logic signed [PW-1:0] icb_reg;
    logic [2*S-1:0]       ssq_b_reg;
    logic [2*MW-1:0]      m2_b_reg;
    logic [MW-1:0]        mb_reg;
    logic [MW-1:0]        qb_reg;
    logic [MW-1:0]        q1b_reg;
    meta_t                mb_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pb_reg      <= PW'(dx_b) * PW'($signed({1'b0, m_b}));
            iab_reg     <= PW'($signed({1'b0, ia_idx})) * PW'(sp_b);
            ibb_reg     <= PW'($signed({1'b0, m_b})) * PW'(sp_b);
            icb_reg     <= PW'($signed({1'b0, ic_idx})) * PW'(sp_b);
            ssq_b_reg   <= (2*S)'(sabs_b) * (2*S)'(sabs_b);
            m2_b_reg    <= (2*MW)'(m_b) * (2*MW)'(m_b);
            mb_reg      <= m_b;
            qb_reg      <= MW'(ka_reg - ja_reg);
            q1b_reg     <= MW'(ka_reg - ja_reg + KW'(1));
            mb_meta_reg <= ma_reg;
        end
    end

    // Stage C: knot distances clipped at zero, m cubed
    logic signed [DW-1:0] da_c;
    logic signed [DW-1:0] db_c;
    logic signed [DW-1:0] dc_c;

    always_comb
    begin
        da_c = DW'(pb_reg) - DW'(iab_reg);
        db_c = DW'(pb_reg) - DW'(ibb_reg);
        dc_c = DW'(pb_reg) - DW'(icb_reg);
    end

    logic              vc_reg;
    logic [UW-1:0]     ua_c_reg;
    logic [UW-1:0]     ub_c_reg;
    logic [UW-1:0]     uc_c_reg;
    logic [3*MW-1:0]   m3_c_reg;
    logic [2*S-1:0]    ssq_c_reg;
    logic [MW-1:0]     qc_reg;
    logic [MW-1:0]     q1c_reg;
    meta_t             mc_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ua_c_reg    <= da_c[DW-1] ? '0 : da_c[UW-1:0];
            ub_c_reg    <= db_c[DW-1] ? '0 : db_c[UW-1:0];
            uc_c_reg    <= dc_c[DW-1] ? '0 : dc_c[UW-1:0];
            m3_c_reg    <= (3*MW)'(m2_b_reg) * (3*MW)'(mb_reg);
            ssq_c_reg   <= ssq_b_reg;
            qc_reg      <= qb_reg;
            q1c_reg     <= q1b_reg;
            mc_meta_reg <= mb_meta_reg;
        end
    end

    // Stage D: squares of distances, divisor core
    logic              vd_reg;
    logic [2*UW-1:0]   sqa_d_reg;
    logic [2*UW-1:0]   sqb_d_reg;
    logic [2*UW-1:0]   sqc_d_reg;
    logic [UW-1:0]     ua_d_reg;
    logic [UW-1:0]     ub_d_reg;
    logic [UW-1:0]     uc_d_reg;
    logic [D0W-1:0]    den0_d_reg;
    logic [MW-1:0]     qd_reg;
    logic [MW-1:0]     q1d_reg;
    meta_t             md_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqa_d_reg   <= (2*UW)'(ua_c_reg) * (2*UW)'(ua_c_reg);
            sqb_d_reg   <= (2*UW)'(ub_c_reg) * (2*UW)'(ub_c_reg);
            sqc_d_reg   <= (2*UW)'(uc_c_reg) * (2*UW)'(uc_c_reg);
            ua_d_reg    <= ua_c_reg;
            ub_d_reg    <= ub_c_reg;
            uc_d_reg    <= uc_c_reg;
            den0_d_reg  <= D0W'(m3_c_reg) * D0W'(ssq_c_reg);
            qd_reg      <= qc_reg;
            q1d_reg     <= q1c_reg;
            md_meta_reg <= mc_meta_reg;
        end
    end

    // Stage E: cube partial products, square split in halves
    logic              ve_reg;
    logic [2*UW-1:0]   pla_e_reg;
    logic [2*UW-1:0]   pha_e_reg;
    logic [2*UW-1:0]   plb_e_reg;
    logic [2*UW-1:0]   phb_e_reg;
    logic [2*UW-1:0]   plc_e_reg;
    logic [2*UW-1:0]   phc_e_reg;
    logic [D0W-1:0]    den0_e_reg;
    logic [MW-1:0]     qe_reg;
    logic [MW-1:0]     q1e_reg;
    meta_t             me_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pla_e_reg   <= (2*UW)'(sqa_d_reg[UW-1:0]) * (2*UW)'(ua_d_reg);
            pha_e_reg   <= (2*UW)'(sqa_d_reg[2*UW-1:UW]) * (2*UW)'(ua_d_reg);
            plb_e_reg   <= (2*UW)'(sqb_d_reg[UW-1:0]) * (2*UW)'(ub_d_reg);
            phb_e_reg   <= (2*UW)'(sqb_d_reg[2*UW-1:UW]) * (2*UW)'(ub_d_reg);
            plc_e_reg   <= (2*UW)'(sqc_d_reg[UW-1:0]) * (2*UW)'(uc_d_reg);
            phc_e_reg   <= (2*UW)'(sqc_d_reg[2*UW-1:UW]) * (2*UW)'(uc_d_reg);
            den0_e_reg  <= den0_d_reg;
            qe_reg      <= qd_reg;
            q1e_reg     <= q1d_reg;
            me_meta_reg <= md_meta_reg;
        end
    end

    // Stage F: cubes assembled
    logic              vf_reg;
    logic [CUW-1:0]    ca_f_reg;
    logic [CUW-1:0]    cb_f_reg;
    logic [CUW-1:0]    cc_f_reg;
    logic [D0W-1:0]    den0_f_reg;
    logic [MW-1:0]     qf_reg;
    logic [MW-1:0]     q1f_reg;
    meta_t             mf_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca_f_reg    <= (CUW'(pha_e_reg) << UW) + CUW'(pla_e_reg);
            cb_f_reg    <= (CUW'(phb_e_reg) << UW) + CUW'(plb_e_reg);
            cc_f_reg    <= (CUW'(phc_e_reg) << UW) + CUW'(plc_e_reg);
            den0_f_reg  <= den0_e_reg;
            qf_reg      <= qe_reg;
            q1f_reg     <= q1e_reg;
            mf_meta_reg <= me_meta_reg;
        end
    end

    // Stage G: tail terms weighted by their small factors
    logic              vg_reg;
    logic [CUW-1:0]    ca_g_reg;
    logic [TW-1:0]     tb_g_reg;
    logic [TW-1:0]     tc_g_reg;
    logic [D0W-1:0]    den0_g_reg;
    meta_t             mg_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca_g_reg    <= ca_f_reg;
            tb_g_reg    <= TW'(cb_f_reg) * TW'(qf_reg);
            tc_g_reg    <= TW'(cc_f_reg) * TW'(q1f_reg);
            den0_g_reg  <= den0_f_reg;
            mg_meta_reg <= mf_meta_reg;
        end
    end

    // Stage H: signed numerator
    logic              vh_reg;
    logic signed [NW-1:0] num_h_reg;
    logic [D0W-1:0]    den0_h_reg;
    meta_t             mh_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_h_reg   <= $signed(NW'(ca_g_reg)) + $signed(NW'(tb_g_reg))
                           - $signed(NW'(tc_g_reg));
            den0_h_reg  <= den0_g_reg;
            mh_meta_reg <= mg_meta_reg;
        end
    end

    // Stage I: magnitude scaled for Q16.16 with one extra rounding bit
    logic signed [NW-1:0] num_neg;
    logic [NW-2:0]        mag_i;
    meta_t                meta_i;

    always_comb
    begin
        num_neg    = -num_h_reg;
        mag_i      = num_h_reg[NW-1] ? num_neg[NW-2:0] : num_h_reg[NW-2:0];
        meta_i     = mh_meta_reg;
        meta_i.neg = num_h_reg[NW-1];
    end

    logic              vi_reg;
    logic [CW-1:0]     rem_i_reg;
    logic [DENW-1:0]   den_i_reg;
    meta_t             mi_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_i_reg   <= CW'({mag_i, 17'h0});
            den_i_reg   <= {den0_h_reg, {S{1'b0}}};
            mi_meta_reg <= meta_i;
        end
    end

    // Valid bits of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= active_reg;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
        end
    end

    // ---------------------------------------------------------------
    // Divider
    logic             dv_valid;
    logic [QBITS-1:0] dv_quo;
    logic             dv_ovf;
    meta_t            dv_meta;

    rcsb_div #(
        .CW   (CW),
        .DENW (DENW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vi_reg),
        .in_rem    (rem_i_reg),
        .in_den    (den_i_reg),
        .in_meta   (mi_meta_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_meta  (dv_meta)
    );

    // ---------------------------------------------------------------
    // Rounding, saturation and column select
    logic [QBITS:0]   rnd_sum;
    logic [QBITS-1:0] rmag;
    logic [31:0]      spline_val;
    logic [31:0]      value_next;

    always_comb
    begin
        rnd_sum = {1'b0, dv_quo} + (QBITS+1)'(1);
        rmag    = rnd_sum[QBITS:1];
        if (dv_meta.neg)
        begin
            if (dv_ovf || rmag > QBITS'(SAT_NEG))
                spline_val = SAT_NEG;
            else
                spline_val = 32'h0 - rmag[31:0];
        end
        else
        begin
            if (dv_ovf || rmag > QBITS'(SAT_POS))
                spline_val = SAT_POS;
            else
                spline_val = rmag[31:0];
        end

        case (dv_meta.kind)
            KIND_CONST:  value_next = ONE_Q16;
            KIND_LIN:    value_next = dv_meta.linval;
            KIND_SPLINE: value_next = dv_meta.zero ? 32'h0 : spline_val;
            default:     value_next = 32'h0;
        endcase
    end

    // Output register
    logic [3:0]  column_reg;
    logic [31:0] value_reg;
    logic        last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            column_reg <= dv_meta.col;
            value_reg  <= value_next;
            last_reg   <= dv_meta.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign column      = column_reg;
    assign basis_value = $signed(value_reg);
    assign last_column = last_reg;

endmodule

// ----- sim/tb_restricted_cubic_spline_basis.sv -----
module tb_restricted_cubic_spline_basis;
    import rcsb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXK      = 16;
    localparam int SBITS     = 16;
    localparam int DRAIN     = 60;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        logic [3:0]  col;
        logic [31:0] val;
        logic        last;
    } basis_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_FIRST_KNOT;
    logic [15:0]        cfg_data = '0;
    logic               sample_valid = 1'b0;
    logic               sample_ready;
    logic [SBITS-1:0]   sample_x = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         column;
    logic signed [31:0] basis_value;
    logic               last_column;

    // shadow copy of the configuration
    logic [15:0] knot_lo = RST_FIRST_KNOT;
    logic [15:0] knot_hi = RST_LAST_KNOT;
    logic [4:0]  knot_cnt = RST_NUM_KNOTS;

    logic [SBITS-1:0] pending_x[$];
    basis_word_t      basis_due[$];
    int  mismatches = 0;
    bit  took = 1'b0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    int  gap_cnt = 0;
    int  burst_cnt = 0;
    int  quiet = 0;

    restricted_cubic_spline_basis u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_x     (sample_x),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column       (column),
        .basis_value  (basis_value),
        .last_column  (last_column)
    );

    always #5 clk = ~clk;

    // cube of the positive part of a knot offset
    function automatic logic [127:0] trunc_cube(longint d);
        logic [127:0] u;
        u = (d > 0) ? 128'(d) : 128'd0;
        return u * u * u;
    endfunction

    // spline column j of k for sample x, exact then rounded and saturated
    function automatic logic [31:0] spline_term(longint x, longint k, longint j);
        longint f, s, m, dx;
        logic [127:0] pos, neg, num, den, mag, rem;
        bit negative;
        f = longint'(knot_lo);
        s = longint'(knot_hi) - f;
        m = k - 1;
        dx = x - f;
        if (s == 0)
            return 32'd0;
        pos = trunc_cube(dx * m - (j - 2) * s)
              + trunc_cube(dx * m - (k - 1) * s) * 128'(k - j);
        neg = trunc_cube(dx * m - (k - 2) * s) * 128'(k - j + 1);
        negative = pos < neg;
        num = (negative ? neg - pos : pos - neg) << 16;
        if (s < 0)
            s = -s;
        den = (128'(m * m * m) * 128'(s * s)) << SBITS;
        mag = num / den;
        rem = num % den;
        if ((rem << 1) >= den)
            mag = mag + 1;
        if (negative)
            return (mag > 128'h8000_0000) ? SAT_NEG : 32'(0 - mag);
        return (mag > 128'h7FFF_FFFF) ? SAT_POS : mag[31:0];
    endfunction

    // queue the run of words one sample produces
    task automatic predict_run(logic [SBITS-1:0] x);
        int k;
        basis_word_t w;
        k = knot_cnt;
        if (k < MIN_KNOTS)
            k = MIN_KNOTS;
        if (k > MAXK)
            k = MAXK;
        for (int j = 0; j < k; j++)
        begin
            w.col = 4'(j);
            w.last = (j == k - 1);
            if (j == 0)
                w.val = ONE_Q16;
            else if (j == 1)
                w.val = 32'(((longint'(x) << 16) + (1 << (SBITS - 1))) >> SBITS);
            else
                w.val = spline_term(longint'(x), k, j);
            basis_due.push_back(w);
        end
    endtask

    // sender: bursts and gaps, fed from pending_x
    always @(negedge clk)
    begin
        if (!sample_valid || took)
        begin
            took = 1'b0;
            if (gap_cnt > 0)
            begin
                gap_cnt--;
                sample_valid <= 1'b0;
            end
            else if (pending_x.size() > 0)
            begin
                sample_x <= pending_x.pop_front();
                sample_valid <= 1'b1;
                if (burst_cnt > 0)
                    burst_cnt--;
                else if (!steady)
                begin
                    burst_cnt = $urandom_range(0, 8);
                    gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // receiver: own stall pattern, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // input acceptance, output check and watchdog
    always @(posedge clk)
    begin
        basis_word_t w;
        if (sample_valid && sample_ready)
        begin
            took = 1'b1;
            predict_run(sample_x);
        end
        if (out_valid && out_ready)
        begin
            if (basis_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word: col %0d val %h last %b",
                             column, basis_value, last_column);
                mismatches++;
            end
            else
            begin
                w = basis_due.pop_front();
                if (column !== w.col || basis_value !== w.val || last_column !== w.last)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp col %0d val %h last %b, got col %0d val %h last %b",
                                 w.col, w.val, w.last, column, basis_value, last_column);
                    mismatches++;
                end
            end
        end
        if ((sample_valid && sample_ready) || (out_valid && out_ready) || !rst_n)
            quiet = 0;
        else if (sample_valid || basis_due.size() > 0)
        begin
            quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_x.size() > 0 || sample_valid || basis_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FIRST_KNOT: knot_lo = data;
            REG_LAST_KNOT:  knot_hi = data;
            default:        knot_cnt = data[4:0];
        endcase
    endtask

    task automatic run_phase(logic [15:0] f, logic [15:0] l, logic [4:0] k, int n);
        wait_idle();
        write_cfg(REG_FIRST_KNOT, f);
        write_cfg(REG_LAST_KNOT, l);
        write_cfg(REG_NUM_KNOTS, {11'($urandom), k});
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: pending_x.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                1: pending_x.push_back(16'(f + $urandom_range(0, 40) - 20));
                2: pending_x.push_back(16'(l + $urandom_range(0, 40) - 20));
                default: pending_x.push_back(16'($urandom));
            endcase
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // defaults from reset: extremes and knot positions
        steady = 1'b1;
        pending_x.push_back(16'h0000);
        pending_x.push_back(16'hFFFF);
        pending_x.push_back(16'd3277);
        pending_x.push_back(16'd62259);
        pending_x.push_back(16'd1);
        pending_x.push_back(16'h8000);
        pending_x.push_back(16'd3276);
        pending_x.push_back(16'd18022);
        pending_x.push_back(16'd47514);
        pending_x.push_back(16'd62260);
        pending_x.push_back(16'h5555);
        pending_x.push_back(16'hAAAA);
        wait_idle();
        steady = 1'b0;

        // full scale with most knots, long output hold while input keeps coming
        run_phase(16'h0000, 16'hFFFF, 5'd16, 24);
        @(posedge clk);
        hold_req = 1'b1;
        // fewest knots; zero span; reversed; knot counts out of range
        run_phase(16'h0000, 16'hFFFF, 5'd3, 20);
        run_phase(16'd1000, 16'd1000, 5'd5, 12);
        run_phase(16'd60000, 16'd2000, 5'd7, 20);
        run_phase(16'h0000, 16'h0000, 5'd31, 8);
        run_phase(16'd100, 16'd200, 5'd0, 16);
        run_phase(16'hFFFF, 16'h0000, 5'd2, 16);
        run_phase(16'd100, 16'd101, 5'd17, 10);
        for (int p = 0; p < 7; p++)
        begin
            steady = (p == 3);
            run_phase(16'($urandom), 16'($urandom), 5'($urandom_range(0, 31)), 18);
        end
        steady = 1'b0;
        run_phase(RST_FIRST_KNOT, RST_LAST_KNOT, RST_NUM_KNOTS, 10);
        wait_idle();

        if (mismatches == 0 && basis_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rcsb_pkg.sv
rtl/core/rcsb_div.sv
rtl/core/restricted_cubic_spline_basis.sv
sim/tb_restricted_cubic_spline_basis.sv
